// ===== src/hash_key_uniquifier_assert.svh =====
// Assertion macros for the key uniquifier. Clock and reset names are those of the modules.
`ifndef HASH_KEY_UNIQUIFIER_ASSERT_SVH
`define HASH_KEY_UNIQUIFIER_ASSERT_SVH

`ifndef SYNTHESIS
`define HKU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define HKU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HKU_ASSERT_IMPL(lbl, ante, cons, msg)
`define HKU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/hku_pkg.sv =====
`timescale 1ns / 1ps

package hku_pkg;

  localparam int unsigned KEY_W         = 64;
  localparam int unsigned OFFSET_W      = 12;
  localparam int unsigned PERTURB_SHIFT = 5;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BWAIT,
    ST_KWAIT,
    ST_CLR_RD,
    ST_CLR_WR
  } state_e;

  // Status of one probe step, from the shared unit to the sequencer.
  typedef struct packed {
    logic key_match;
    key_t next_perturb;
  } step_status_t;

endpackage

// ===== src/hash_key_uniquifier.sv =====
`timescale 1ns / 1ps
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+-----------------------------------
// command  | key_i, last_in_batch_i                 | start && !busy transfers one key
// result   | offset_o, is_new_o, overflow_o         | result_valid_o, one cycle, no stall
//
// A key is resolved by visiting buckets of one bucket RAM: for each empty bucket reached,
// a bucket read; for each occupied bucket, a bucket read, then a key store read and
// compare. A new key whose home bucket is empty gives its result strobe after its bucket
// read; a key found in its home bucket gives it after the key store read and compare.
// After reset every bucket of the bucket RAM is cleared once, with busy high.
// After the last key of a batch, its buckets are cleared through a list of inserted
// buckets, each read from the list, then cleared. The receiver cannot stall results.

`include "hash_key_uniquifier_assert.svh"

module hash_key_uniquifier import hku_pkg::*; #(
  parameter int unsigned TABLE_BUCKETS = 8192,
  parameter int unsigned MAX_UNIQUE    = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  key_t                key_i,
  input  logic                last_in_batch_i,
  output logic                result_valid_o,
  output logic [OFFSET_W-1:0] offset_o,
  output logic                is_new_o,
  output logic                overflow_o
);

  localparam int unsigned BW          = $clog2(TABLE_BUCKETS);
  localparam int unsigned IW          = $clog2(MAX_UNIQUE);
  localparam int unsigned CW          = $clog2(MAX_UNIQUE + 1);
  localparam int unsigned ProbeLimit  = 2 * TABLE_BUCKETS + 16;
  localparam int unsigned NW          = $clog2(ProbeLimit + 1);
  localparam int unsigned EW          = IW + 1;

  localparam logic [BW-1:0] BucketMask = BW'(TABLE_BUCKETS - 1);
  localparam logic [BW-1:0] LastBucket = BW'(TABLE_BUCKETS - 1);
  localparam logic [CW-1:0] CntMax     = CW'(MAX_UNIQUE);
  localparam logic [NW-1:0] LastProbe  = NW'(ProbeLimit - 1);

  state_e        state_q, state_d;
  key_t          key_q, key_d;
  logic          last_q, last_d;
  key_t          perturb_q, perturb_d;
  logic [BW-1:0] bucket_q, bucket_d;
  logic [NW-1:0] probes_q, probes_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [IW-1:0] hit_q, hit_d;

  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic                is_new_q, is_new_d;
  logic                ovf_q, ovf_d;
  logic                rvalid_q, rvalid_d;

  // RAM ports
  logic          bk_we, bk_re;
  logic [BW-1:0] bk_waddr;
  logic [EW-1:0] bk_wdata, bk_rdata;
  logic          ks_we, ks_re;
  logic [IW-1:0] ks_raddr;
  key_t          ks_rdata;
  logic          sl_we, sl_re;
  logic [BW-1:0] sl_rdata;

  logic          b_used;
  logic [IW-1:0] b_idx;
  logic          room;
  logic [BW-1:0] next_bucket;
  step_status_t  step_st;
  state_e        done_state;

  assign b_used     = bk_rdata[IW];
  assign b_idx      = bk_rdata[IW-1:0];
  assign room       = (cnt_q < CntMax);
  assign done_state = last_q ? ST_CLR_RD : ST_IDLE;

  hku_step #(
    .TABLE_BUCKETS(TABLE_BUCKETS)
  ) u_step (
    .key_i        (key_q),
    .stored_i     (ks_rdata),
    .perturb_i    (perturb_q),
    .bucket_i     (bucket_q),
    .next_bucket_o(next_bucket),
    .status_o     (step_st)
  );

  // Bucket entry: {used, store index}
  hku_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_BUCKETS)
  ) u_bucket_ram (
    .clk_i  (clk_i),
    .we_i   (bk_we),
    .waddr_i(bk_waddr),
    .wdata_i(bk_wdata),
    .re_i   (bk_re),
    .raddr_i(bucket_d),
    .rdata_o(bk_rdata)
  );

  hku_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_UNIQUE)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ks_we),
    .waddr_i(cnt_q[IW-1:0]),
    .wdata_i(key_q),
    .re_i   (ks_re),
    .raddr_i(ks_raddr),
    .rdata_o(ks_rdata)
  );

  // Buckets filled in this batch, walked at batch end to clear them.
  hku_ram #(
    .WIDTH(BW),
    .DEPTH(MAX_UNIQUE)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (sl_we),
    .waddr_i(cnt_q[IW-1:0]),
    .wdata_i(bucket_q),
    .re_i   (sl_re),
    .raddr_i(clr_q[IW-1:0]),
    .rdata_o(sl_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (bucket_q == LastBucket) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_BWAIT;
      end
      ST_BWAIT: begin
        state_d = b_used ? ST_KWAIT : done_state;
      end
      ST_KWAIT: begin
        if (step_st.key_match || probes_q == LastProbe) state_d = done_state;
        else state_d = ST_BWAIT;
      end
      ST_CLR_RD: begin
        state_d = (clr_q == cnt_q) ? ST_IDLE : ST_CLR_WR;
      end
      ST_CLR_WR: begin
        state_d = ST_CLR_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    key_d     = key_q;
    last_d    = last_q;
    perturb_d = perturb_q;
    bucket_d  = bucket_q;
    probes_d  = probes_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    hit_d     = hit_q;
    offset_d  = offset_q;
    is_new_d  = is_new_q;
    ovf_d     = ovf_q;
    rvalid_d  = 1'b0;
    bk_we     = 1'b0;
    bk_re     = 1'b0;
    bk_waddr  = bucket_q;
    bk_wdata  = '0;
    ks_we     = 1'b0;
    ks_re     = 1'b0;
    ks_raddr  = b_idx;
    sl_we     = 1'b0;
    sl_re     = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        bk_we    = 1'b1;
        bucket_d = bucket_q + BW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          key_d     = key_i;
          last_d    = last_in_batch_i;
          perturb_d = key_i;
          bucket_d  = key_i[BW-1:0] & BucketMask;
          probes_d  = '0;
          bk_re     = 1'b1;
        end
      end
      ST_BWAIT: begin
        if (b_used) begin
          hit_d = b_idx;
          ks_re = 1'b1;
        end else begin
          rvalid_d = 1'b1;
          if (room) begin
            bk_we    = 1'b1;
            bk_wdata = {1'b1, cnt_q[IW-1:0]};
            ks_we    = 1'b1;
            sl_we    = 1'b1;
            cnt_d    = cnt_q + CW'(1);
            offset_d = OFFSET_W'(cnt_q[IW-1:0]);
            is_new_d = 1'b1;
            ovf_d    = 1'b0;
          end else begin
            offset_d = '0;
            is_new_d = 1'b0;
            ovf_d    = 1'b1;
          end
          clr_d = '0;
        end
      end
      ST_KWAIT: begin
        if (step_st.key_match) begin
          rvalid_d = 1'b1;
          offset_d = OFFSET_W'(hit_q);
          is_new_d = 1'b0;
          ovf_d    = 1'b0;
          clr_d    = '0;
        end else if (probes_q == LastProbe) begin
          rvalid_d = 1'b1;
          offset_d = '0;
          is_new_d = 1'b0;
          ovf_d    = 1'b1;
          clr_d    = '0;
        end else begin
          perturb_d = step_st.next_perturb;
          bucket_d  = next_bucket;
          probes_d  = probes_q + NW'(1);
          bk_re     = 1'b1;
        end
      end
      ST_CLR_RD: begin
        if (clr_q == cnt_q) begin
          cnt_d = '0;
        end else begin
          sl_re = 1'b1;
        end
      end
      ST_CLR_WR: begin
        bk_we    = 1'b1;
        bk_waddr = sl_rdata;
        clr_d    = clr_q + CW'(1);
      end
      default: begin
        rvalid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      bucket_q <= '0;
      probes_q <= '0;
      cnt_q    <= '0;
      clr_q    <= '0;
      last_q   <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      bucket_q <= bucket_d;
      probes_q <= probes_d;
      cnt_q    <= cnt_d;
      clr_q    <= clr_d;
      last_q   <= last_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    perturb_q <= perturb_d;
    hit_q     <= hit_d;
    offset_q  <= offset_d;
    is_new_q  <= is_new_d;
    ovf_q     <= ovf_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = rvalid_q;
  assign offset_o       = offset_q;
  assign is_new_o       = is_new_q;
  assign overflow_o     = ovf_q;

  `HKU_ASSERT_IMPL(a_new_xor_ovf, result_valid_o, !(is_new_o && overflow_o), "new key flagged as overflow")
  `HKU_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "transfer did not raise busy")
  `HKU_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o, "result strobe longer than one cycle")
  `HKU_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CntMax, "unique count beyond store depth")

endmodule

// ===== src/hku_ram.sv =====
`timescale 1ns / 1ps

module hku_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/hku_step.sv =====
`timescale 1ns / 1ps

module hku_step import hku_pkg::*; #(
  parameter int unsigned TABLE_BUCKETS = 8192,
  localparam int unsigned BW = $clog2(TABLE_BUCKETS)
) (
  input  key_t         key_i,
  input  key_t         stored_i,
  input  key_t         perturb_i,
  input  logic [BW-1:0] bucket_i,
  output logic [BW-1:0] next_bucket_o,
  output step_status_t  status_o
);

  localparam logic [BW-1:0] BucketMask = BW'(TABLE_BUCKETS - 1);

  key_t          perturb_sh;
  logic [BW-1:0] sum;

  // Next probe: (b*5 + 1 + (perturb >> 5)) & mask; only the low bucket bits matter.
  assign perturb_sh    = perturb_i >> PERTURB_SHIFT;
  assign sum           = (bucket_i << 2) + bucket_i + perturb_sh[BW-1:0] + BW'(1);
  assign next_bucket_o = sum & BucketMask;

  assign status_o.key_match    = (stored_i == key_i);
  assign status_o.next_perturb = perturb_sh;

endmodule

// ===== tb/hku_checker.sv =====
`timescale 1ns / 1ps

module hku_checker import hku_pkg::*; #(
  parameter int unsigned TABLE_BUCKETS = 8192,
  parameter int unsigned MAX_UNIQUE    = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  key_t                key_i,
  input  logic                last_in_batch_i,
  input  logic                result_valid_i,
  input  logic [OFFSET_W-1:0] offset_i,
  input  logic                is_new_i,
  input  logic                overflow_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);

  localparam int unsigned ENTRY_W     = $clog2(MAX_UNIQUE) + 1;
  localparam int unsigned PROBE_LIMIT = 2 * TABLE_BUCKETS + 16;
  localparam key_t        BUCKET_MASK = key_t'(TABLE_BUCKETS - 1);
  localparam key_t        PROBE_MUL   = key_t'(5);

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                is_new;
    logic                overflow;
  } dedup_result_t;

  logic [ENTRY_W-1:0] bucket_entry [TABLE_BUCKETS];
  bit                 bucket_full  [TABLE_BUCKETS];
  key_t               unique_keys  [MAX_UNIQUE];
  int unsigned        unique_count;
  dedup_result_t      expected_q   [$];
  int                 mismatches = 0;
  int                 pending    = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  task automatic clear_batch();
    for (int i = 0; i < TABLE_BUCKETS; i++) begin
      bucket_full[i]  = 1'b0;
      bucket_entry[i] = '0;
    end
    unique_count = 0;
  endtask

  // Walk the perturbed probe path; insert on the first empty bucket if room is left.
  task automatic resolve_key(input key_t key, output dedup_result_t res);
    key_t        perturb;
    key_t        bucket;
    key_t        stored;
    int unsigned entry;
    int unsigned slot;
    bit          found;
    bit          empty_seen;
    perturb    = key;
    bucket     = key & BUCKET_MASK;
    entry      = 0;
    slot       = 0;
    found      = 1'b0;
    empty_seen = 1'b0;
    res        = '0;
    for (int unsigned n = 0; n < PROBE_LIMIT && !found && !empty_seen; n++) begin
      if (!bucket_full[bucket]) begin
        empty_seen = 1'b1;
        slot       = 32'(bucket);
      end else begin
        entry  = 32'(bucket_entry[bucket]);
        stored = (entry < MAX_UNIQUE) ? unique_keys[entry] : '0;
        if (stored == key) begin
          found = 1'b1;
        end else begin
          perturb = perturb >> PERTURB_SHIFT;
          bucket  = (bucket * PROBE_MUL + key_t'(1) + perturb) & BUCKET_MASK;
        end
      end
    end
    if (found) begin
      res.offset = OFFSET_W'(entry);
    end else if (empty_seen && unique_count < MAX_UNIQUE) begin
      unique_keys[unique_count] = key;
      bucket_entry[slot]        = ENTRY_W'(unique_count);
      bucket_full[slot]         = 1'b1;
      res.offset                = OFFSET_W'(unique_count);
      res.is_new                = 1'b1;
      unique_count++;
    end else begin
      res.overflow = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dedup_result_t want;
    dedup_result_t fresh;
    if (!rst_ni) begin
      clear_batch();
      expected_q.delete();
      pending = 0;
    end else begin
      // result first: it always belongs to an earlier transfer
      if (result_valid_i === 1'b1) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: offset %0d is_new %0b overflow %0b",
                   $time, offset_i, is_new_i, overflow_i);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (offset_i !== want.offset) begin
            $display("%0t: offset mismatch: expected %0d, actual %0d",
                     $time, want.offset, offset_i);
            mismatches++;
          end
          if (is_new_i !== want.is_new) begin
            $display("%0t: is_new mismatch: expected %0b, actual %0b",
                     $time, want.is_new, is_new_i);
            mismatches++;
          end
          if (overflow_i !== want.overflow) begin
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, want.overflow, overflow_i);
            mismatches++;
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        resolve_key(key_i, fresh);
        expected_q = {expected_q, fresh};
        if (last_in_batch_i) clear_batch();
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hku_pkg::*;

  localparam int unsigned TABLE_BUCKETS  = 8192;
  localparam int unsigned MAX_UNIQUE     = 4096;
  localparam int          RANDOM_ITEMS   = 1900;
  // covers the sweep after reset and a clear of a full store, several times over
  localparam int          WATCHDOG_LIMIT = 40000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  key_t                key_i;
  logic                last_in_batch_i;
  logic                result_valid_o;
  logic [OFFSET_W-1:0] offset_o;
  logic                is_new_o;
  logic                overflow_o;

  int   fail_count;
  int   pending;
  int   idle_run;
  int   burst_left;
  key_t batch_keys [$];
  key_t full_keys  [MAX_UNIQUE];

  hash_key_uniquifier #(
    .TABLE_BUCKETS (TABLE_BUCKETS),
    .MAX_UNIQUE    (MAX_UNIQUE)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .key_i           (key_i),
    .last_in_batch_i (last_in_batch_i),
    .result_valid_o  (result_valid_o),
    .offset_o        (offset_o),
    .is_new_o        (is_new_o),
    .overflow_o      (overflow_o)
  );

  hku_checker #(
    .TABLE_BUCKETS (TABLE_BUCKETS),
    .MAX_UNIQUE    (MAX_UNIQUE)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .key_i            (key_i),
    .last_in_batch_i  (last_in_batch_i),
    .result_valid_i   (result_valid_o),
    .offset_i         (offset_o),
    .is_new_i         (is_new_o),
    .overflow_i       (overflow_o),
    .mismatch_count_o (fail_count),
    .pending_o        (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // counts cycles in which neither a key nor a result is transferred
  initial idle_run = 0;
  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || result_valid_o === 1'b1) idle_run <= 0;
    else idle_run <= idle_run + 1;
  end

  initial begin
    wait (idle_run >= WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic idle_cycle();
    @(negedge clk_i);
    start           = 1'b0;
    key_i           = {$urandom, $urandom};
    last_in_batch_i = 1'($urandom_range(0, 1));
  endtask

  task automatic send_key(input key_t key, input logic last);
    @(negedge clk_i);
    start           = 1'b1;
    key_i           = key;
    last_in_batch_i = last;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // sender works in bursts with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      repeat (gap) idle_cycle();
    end
    burst_left--;
  endtask

  task automatic drain();
    while (pending != 0) idle_cycle();
  endtask

  // repeats, keys sharing a few home buckets, extremes and plain random keys
  function automatic key_t pick_key();
    key_t        k;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    k   = {$urandom, $urandom};
    if (sel < 40 && batch_keys.size() > 0) begin
      k = batch_keys[$urandom_range(0, batch_keys.size() - 1)];
    end else if (sel < 65) begin
      k[12:0] = {11'h5a3, 2'($urandom_range(0, 3))};
    end else if (sel < 72) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k = key_t'(1) << $urandom_range(0, KEY_W - 1);
        default: k = ~(key_t'(1) << $urandom_range(0, KEY_W - 1));
      endcase
    end
    return k;
  endfunction

  initial begin : stimulus
    int   sent;
    int   batch_len;
    key_t k;
    rst_ni          = 1'b0;
    start           = 1'b0;
    key_i           = '0;
    last_in_batch_i = 1'b0;
    burst_left      = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, home-bucket collisions, lookups through the probe path
    send_key('0, 1'b0);
    send_key('1, 1'b0);
    send_key('0, 1'b0);
    send_key(64'h8000_0000_0000_0000, 1'b0);
    send_key(64'h0000_0000_0000_2000, 1'b0);
    send_key(64'h0000_0000_0000_2000, 1'b0);
    send_key(64'h8000_0000_0000_0000, 1'b0);
    send_key('1, 1'b1);
    // table must be empty again
    send_key('1, 1'b0);
    send_key(64'h5555_5555_5555_5555, 1'b0);
    send_key(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_key('0, 1'b0);
    send_key(64'h5555_5555_5555_5555, 1'b0);
    send_key(64'h0123_4567_89ab_cdef, 1'b1);
    // one-key batches, then a two-key batch of one repeated key
    send_key(64'h0123_4567_89ab_cdef, 1'b1);
    send_key(64'h0123_4567_89ab_cdef, 1'b1);
    send_key(64'hfedc_ba98_7654_3210, 1'b0);
    send_key(64'hfedc_ba98_7654_3210, 1'b1);
    idle_cycle();
    drain();

    // fill the unique store, then hit it with repeats and new keys
    for (int i = 0; i < MAX_UNIQUE; i++) begin
      k = {$urandom, $urandom};
      k[11:0] = 12'(i);
      full_keys[i] = k;
      pace();
      send_key(k, 1'b0);
    end
    for (int i = 0; i < 12; i++) begin
      pace();
      if (i % 2 == 0) send_key(full_keys[$urandom_range(0, MAX_UNIQUE - 1)], 1'b0);
      else send_key({$urandom, $urandom}, 1'b0);
    end
    // overflow on the last key still clears the table
    send_key({$urandom, $urandom}, 1'b1);
    send_key(full_keys[0], 1'b0);
    send_key(full_keys[MAX_UNIQUE - 1], 1'b1);
    idle_cycle();
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      batch_len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 500)
                                               : $urandom_range(1, 48);
      batch_keys.delete();
      for (int i = 0; i < batch_len; i++) begin
        k = pick_key();
        pace();
        send_key(k, logic'(i == batch_len - 1));
        batch_keys = {batch_keys, k};
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        idle_cycle();
        drain();
      end
    end

    idle_cycle();
    drain();
    repeat (64) idle_cycle();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
